// File: rtl/v2dc_pkg.sv
// Shared types and constants for the valid-mode 2D convolution block.
package v2dc_pkg;

	localparam int KERNEL_ROWS_DEF = 3;
	localparam int KERNEL_COLS_DEF = 3;
	localparam int IMAGE_ROWS_DEF  = 32;
	localparam int IMAGE_COLS_DEF  = 32;
	localparam int SAMPLE_BITS_DEF = 16;

	localparam int VALUE_W   = 16;
	localparam int POS_OUT_W = 5;
	localparam int OUT_DATA_W = 32;

	localparam logic KIND_KERNEL = 1'b0;
	localparam logic KIND_IMAGE  = 1'b1;

	// Per-cycle update strobes from the control path to the window datapath.
	typedef struct packed {
		logic kern_we;
		logic img_we;
	} v2dc_ctl_t;

endpackage

// File: rtl/v2dc_line_buf.sv
// Column store holding the previous kernel rows of each image column.
module v2dc_line_buf #(
	parameter int DEPTH  = v2dc_pkg::IMAGE_COLS_DEF,
	parameter int WIDTH  = 2 * v2dc_pkg::SAMPLE_BITS_DEF,
	parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic              clk,
	input  logic              rd_en,
	input  logic [ADDR_W-1:0] rd_addr,
	input  logic              wr_en,
	input  logic [ADDR_W-1:0] wr_addr,
	input  logic [WIDTH-1:0]  wr_data,
	output logic [WIDTH-1:0]  rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	// forward a write that lands on the address being read in the same cycle
	always_ff @(posedge clk) begin
		if (rd_en) begin
			if (wr_en && (wr_addr == rd_addr)) begin
				rd_data_q <= wr_data;
			end else begin
				rd_data_q <= mem_q[rd_addr];
			end
		end
	end

	assign rd_data = rd_data_q;

endmodule

// File: rtl/v2dc_window.sv
// Kernel store, sliding sample window and window sum of products.
module v2dc_window #(
	parameter int KERNEL_ROWS = v2dc_pkg::KERNEL_ROWS_DEF,
	parameter int KERNEL_COLS = v2dc_pkg::KERNEL_COLS_DEF,
	parameter int SAMPLE_BITS = v2dc_pkg::SAMPLE_BITS_DEF,
	parameter int LB_W        = (KERNEL_ROWS > 1) ? (KERNEL_ROWS - 1) * SAMPLE_BITS
	                                              : SAMPLE_BITS
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  v2dc_pkg::v2dc_ctl_t    ctl,
	input  logic [SAMPLE_BITS-1:0] sample,
	input  logic [LB_W-1:0]        lb_rd_data,
	output logic [LB_W-1:0]        lb_wr_data,
	output logic [SAMPLE_BITS-1:0] sum
);

	localparam int KSIZE = KERNEL_ROWS * KERNEL_COLS;
	localparam int KCNT_W = (KSIZE > 1) ? $clog2(KSIZE) : 1;

	logic [SAMPLE_BITS-1:0] kern_q [KSIZE];
	logic [KCNT_W-1:0]      kcnt_q;
	logic [SAMPLE_BITS-1:0] win_q  [KERNEL_ROWS][KERNEL_COLS];
	logic [SAMPLE_BITS-1:0] colvec [KERNEL_ROWS];
	logic [SAMPLE_BITS-1:0] view   [KERNEL_ROWS][KERNEL_COLS];

	// column entering the window: stored rows oldest first, new sample on top
	always_comb begin
		for (int r = 0; r < KERNEL_ROWS; r++) begin
			if (r == KERNEL_ROWS - 1) begin
				colvec[r] = sample;
			end else begin
				colvec[r] = lb_rd_data[r*SAMPLE_BITS +: SAMPLE_BITS];
			end
		end
	end

	// drop the oldest row, append the new sample
	always_comb begin
		lb_wr_data = '0;
		for (int r = 0; r < KERNEL_ROWS - 1; r++) begin
			lb_wr_data[r*SAMPLE_BITS +: SAMPLE_BITS] = colvec[r+1];
		end
		if (KERNEL_ROWS == 1) begin
			lb_wr_data[SAMPLE_BITS-1:0] = sample;
		end
	end

	// window as it stands once the new column is shifted in
	always_comb begin
		for (int r = 0; r < KERNEL_ROWS; r++) begin
			for (int k = 0; k < KERNEL_COLS; k++) begin
				if (k == KERNEL_COLS - 1) begin
					view[r][k] = colvec[r];
				end else begin
					view[r][k] = win_q[r][k+1];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.img_we) begin
			for (int r = 0; r < KERNEL_ROWS; r++) begin
				for (int k = 0; k < KERNEL_COLS; k++) begin
					win_q[r][k] <= view[r][k];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.kern_we) begin
			kern_q[kcnt_q] <= sample;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kcnt_q <= '0;
		end else if (ctl.kern_we) begin
			if (kcnt_q == KCNT_W'(KSIZE - 1)) begin
				kcnt_q <= '0;
			end else begin
				kcnt_q <= kcnt_q + 1'b1;
			end
		end
	end

	// products and sum wrap at the sample width
	always_comb begin
		sum = '0;
		for (int r = 0; r < KERNEL_ROWS; r++) begin
			for (int k = 0; k < KERNEL_COLS; k++) begin
				sum = sum + SAMPLE_BITS'(view[r][k] * kern_q[r*KERNEL_COLS + k]);
			end
		end
	end

endmodule

// File: rtl/valid_2d_convolution.sv
// Top level of the streaming valid-mode 2D convolution block.
// A result item passes the input register, then the result register, once the image
// item that completes its window is accepted. Throughput: one item per cycle, kernel or
// image, unless a held result stalls the flow; the line buffer is read on accept and
// written back as the item leaves the input register, so the port count sets the rate.
// Reset: arst_n clears the image position, kernel slot count and valid flags; sample and
// kernel storage is left unset until written.
module valid_2d_convolution #(
	parameter int KERNEL_ROWS = v2dc_pkg::KERNEL_ROWS_DEF,
	parameter int KERNEL_COLS = v2dc_pkg::KERNEL_COLS_DEF,
	parameter int IMAGE_ROWS  = v2dc_pkg::IMAGE_ROWS_DEF,
	parameter int IMAGE_COLS  = v2dc_pkg::IMAGE_COLS_DEF,
	parameter int SAMPLE_BITS = v2dc_pkg::SAMPLE_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	input  logic [v2dc_pkg::VALUE_W-1:0]      s_tdata,  // [15:0] value
	input  logic                              s_tuser,  // [0] kind
	output logic                              m_tvalid,
	input  logic                              m_tready,
	// [15:0] out_value, [20:16] out_row, [25:21] out_col, [31:26] zero
	output logic [v2dc_pkg::OUT_DATA_W-1:0]   m_tdata,
	output logic                              m_tlast
);

	localparam int ROW_W = (IMAGE_ROWS > 1) ? $clog2(IMAGE_ROWS) : 1;
	localparam int COL_W = (IMAGE_COLS > 1) ? $clog2(IMAGE_COLS) : 1;
	localparam int LB_W  = (KERNEL_ROWS > 1) ? (KERNEL_ROWS - 1) * SAMPLE_BITS : SAMPLE_BITS;
	localparam int PW    = v2dc_pkg::POS_OUT_W;
	localparam int VW    = v2dc_pkg::VALUE_W;

	// position of the next image item
	logic [ROW_W-1:0] row_q;
	logic [COL_W-1:0] col_q;

	// input register stage
	logic                   valid_s1;
	logic                   kind_s1;
	logic [SAMPLE_BITS-1:0] sample_s1;
	logic [ROW_W-1:0]       row_s1;
	logic [COL_W-1:0]       col_s1;

	// result register
	logic          out_valid_q;
	logic [VW-1:0] out_value_q;
	logic [PW-1:0] out_row_q;
	logic [PW-1:0] out_col_q;
	logic          out_last_q;

	logic                   in_acc;
	logic                   adv_s1;
	logic                   img_in;
	logic                   res_s1;
	logic                   last_s1;
	logic [ROW_W-1:0]       orow_s1;
	logic [COL_W-1:0]       ocol_s1;
	logic [LB_W-1:0]        lb_rd_data;
	logic [LB_W-1:0]        lb_wr_data;
	logic [SAMPLE_BITS-1:0] sum_s1;
	v2dc_pkg::v2dc_ctl_t    ctl;

	// advance the input stage whenever the result register is free or draining
	assign adv_s1   = valid_s1 && (!out_valid_q || m_tready);
	assign s_tready = !valid_s1 || adv_s1;
	assign in_acc   = s_tvalid && s_tready;
	assign img_in   = in_acc && (s_tuser == v2dc_pkg::KIND_IMAGE);

	// step the raster position on each accepted image item, wrap at frame end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q <= '0;
			col_q <= '0;
		end else if (img_in) begin
			if (col_q == COL_W'(IMAGE_COLS - 1)) begin
				col_q <= '0;
				if (row_q == ROW_W'(IMAGE_ROWS - 1)) begin
					row_q <= '0;
				end else begin
					row_q <= row_q + 1'b1;
				end
			end else begin
				col_q <= col_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	// payload of the input stage; position is captured as seen on accept
	always_ff @(posedge clk) begin
		if (in_acc) begin
			kind_s1   <= s_tuser;
			sample_s1 <= SAMPLE_BITS'($signed(s_tdata));
			row_s1    <= row_q;
			col_s1    <= col_q;
		end
	end

	// kernel items load a coefficient, image items shift the window and write back
	assign ctl.kern_we = adv_s1 && (kind_s1 == v2dc_pkg::KIND_KERNEL);
	assign ctl.img_we  = adv_s1 && (kind_s1 == v2dc_pkg::KIND_IMAGE);

	v2dc_line_buf #(
		.DEPTH (IMAGE_COLS),
		.WIDTH (LB_W),
		.ADDR_W(COL_W)
	) u_line_buf (
		.clk    (clk),
		.rd_en  (in_acc),
		.rd_addr(col_q),
		.wr_en  (ctl.img_we),
		.wr_addr(col_s1),
		.wr_data(lb_wr_data),
		.rd_data(lb_rd_data)
	);

	v2dc_window #(
		.KERNEL_ROWS(KERNEL_ROWS),
		.KERNEL_COLS(KERNEL_COLS),
		.SAMPLE_BITS(SAMPLE_BITS),
		.LB_W       (LB_W)
	) u_window (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (ctl),
		.sample    (sample_s1),
		.lb_rd_data(lb_rd_data),
		.lb_wr_data(lb_wr_data),
		.sum       (sum_s1)
	);

	// a result needs a full window above and to the left of this sample
	assign res_s1  = (kind_s1 == v2dc_pkg::KIND_IMAGE)
	               && (int'(row_s1) >= KERNEL_ROWS - 1)
	               && (int'(col_s1) >= KERNEL_COLS - 1);
	assign last_s1 = (row_s1 == ROW_W'(IMAGE_ROWS - 1)) && (col_s1 == COL_W'(IMAGE_COLS - 1));
	assign orow_s1 = row_s1 - ROW_W'(KERNEL_ROWS - 1);
	assign ocol_s1 = col_s1 - COL_W'(KERNEL_COLS - 1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv_s1 && res_s1) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && res_s1) begin
			out_value_q <= VW'($signed(sum_s1));
			out_row_q   <= PW'(orow_s1);
			out_col_q   <= PW'(ocol_s1);
			out_last_q  <= last_s1;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tlast  = out_last_q;
	assign m_tdata  = {(v2dc_pkg::OUT_DATA_W - VW - 2 * PW)'(0), out_col_q, out_row_q,
	                   out_value_q};

`ifndef NO_ASSERTIONS
	a_col_range: assert property (@(posedge clk) disable iff (!arst_n)
		int'(col_q) < IMAGE_COLS)
		else $error("image column counter out of range");

	a_row_range: assert property (@(posedge clk) disable iff (!arst_n)
		int'(row_q) < IMAGE_ROWS)
		else $error("image row counter out of range");

	a_result_lands: assert property (@(posedge clk) disable iff (!arst_n)
		(adv_s1 && res_s1) |=> m_tvalid)
		else $error("result item lost between input and result register");

	a_last_pos: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tlast) |-> (out_col_q == PW'(IMAGE_COLS - KERNEL_COLS)
		                           && out_row_q == PW'(IMAGE_ROWS - KERNEL_ROWS)))
		else $error("last marked away from the final window");

	a_no_write_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s1 |-> !(ctl.img_we || ctl.kern_we))
		else $error("store update with empty input stage");
`endif

endmodule

// File: verif/valid_2d_convolution_checker.sv
// Checker that predicts and compares the result items of the 2D convolution block.
module valid_2d_convolution_checker #(
	parameter int KERNEL_ROWS = v2dc_pkg::KERNEL_ROWS_DEF,
	parameter int KERNEL_COLS = v2dc_pkg::KERNEL_COLS_DEF,
	parameter int IMAGE_ROWS  = v2dc_pkg::IMAGE_ROWS_DEF,
	parameter int IMAGE_COLS  = v2dc_pkg::IMAGE_COLS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	input  logic                            s_tready,
	input  logic [v2dc_pkg::VALUE_W-1:0]    s_tdata,  // [15:0] value
	input  logic                            s_tuser,  // [0] kind
	input  logic                            m_tvalid,
	input  logic                            m_tready,
	// [15:0] out_value, [20:16] out_row, [25:21] out_col, [31:26] zero
	input  logic [v2dc_pkg::OUT_DATA_W-1:0] m_tdata,
	input  logic                            m_tlast,
	output int                              fails,
	output int                              pending
);

	localparam int COEF_COUNT = KERNEL_ROWS * KERNEL_COLS;
	localparam int PW = v2dc_pkg::POS_OUT_W;
	localparam int VW = v2dc_pkg::VALUE_W;

	typedef struct {
		logic [VW-1:0] value;
		logic [PW-1:0] row;
		logic [PW-1:0] col;
		logic          last;
	} window_sum_t;

	window_sum_t   window_sums[$];
	logic [VW-1:0] coefs[COEF_COUNT];
	logic [VW-1:0] lines[KERNEL_ROWS][IMAGE_COLS];
	int            coef_slot;
	int            img_row;
	int            img_col;

	always @(posedge clk or negedge arst_n) begin : track
		window_sum_t        want;
		logic [VW-1:0]      acc;
		logic signed [31:0] prod;
		int                 c0;
		int                 line;
		if (!arst_n) begin
			coef_slot = 0;
			img_row = 0;
			img_col = 0;
			fails = 0;
			window_sums.delete();
		end else begin
			// Take the accepted input item first: a result leaving at this edge always
			// belongs to an earlier item, so queue order is kept.
			if (s_tvalid && s_tready) begin
				if (s_tuser == v2dc_pkg::KIND_KERNEL) begin
					coefs[coef_slot] = s_tdata;
					coef_slot = (coef_slot + 1) % COEF_COUNT;
				end else begin
					lines[img_row % KERNEL_ROWS][img_col] = s_tdata;
					if (img_row + 1 >= KERNEL_ROWS && img_col + 1 >= KERNEL_COLS) begin
						acc = '0;
						c0 = img_col + 1 - KERNEL_COLS;
						for (int r = 0; r < KERNEL_ROWS; r++) begin
							// oldest line of the window sits just after the newest one
							line = (img_row + 1 + r) % KERNEL_ROWS;
							for (int k = 0; k < KERNEL_COLS; k++) begin
								prod = $signed(lines[line][c0 + k]) *
									$signed(coefs[r * KERNEL_COLS + k]);
								acc = acc + prod[VW-1:0];
							end
						end
						want.value = acc;
						want.row = PW'(img_row + 1 - KERNEL_ROWS);
						want.col = PW'(c0);
						want.last = (img_row == IMAGE_ROWS - 1) && (img_col == IMAGE_COLS - 1);
						window_sums.push_back(want);
					end
					img_col++;
					if (img_col == IMAGE_COLS) begin
						img_col = 0;
						img_row++;
						if (img_row == IMAGE_ROWS)
							img_row = 0;
					end
				end
			end
			if (m_tvalid && m_tready) begin
				if (window_sums.size() == 0) begin
					$error("unexpected result item: tdata %h tlast %b", m_tdata, m_tlast);
					fails++;
				end else begin
					want = window_sums.pop_front();
					if (m_tdata[15:0] !== want.value) begin
						$error("out_value: expected %0d, got %0d",
							$signed(want.value), $signed(m_tdata[15:0]));
						fails++;
					end
					if (m_tdata[20:16] !== want.row) begin
						$error("out_row: expected %0d, got %0d", want.row, m_tdata[20:16]);
						fails++;
					end
					if (m_tdata[25:21] !== want.col) begin
						$error("out_col: expected %0d, got %0d", want.col, m_tdata[25:21]);
						fails++;
					end
					if (m_tdata[31:26] !== '0) begin
						$error("pad: expected 0, got %0h", m_tdata[31:26]);
						fails++;
					end
					if (m_tlast !== want.last) begin
						$error("last: expected %b, got %b", want.last, m_tlast);
						fails++;
					end
				end
			end
		end
		pending = window_sums.size();
	end

endmodule

// File: verif/valid_2d_convolution_test.sv
// Testbench top: drives kernel and image items into the block and gives the verdict.
module valid_2d_convolution_test;

	localparam int CYCLE_LIMIT = 200000;

	logic                            clk;
	logic                            arst_n;
	logic                            s_tvalid;
	logic                            s_tready;
	logic [v2dc_pkg::VALUE_W-1:0]    s_tdata;   // [15:0] value
	logic                            s_tuser;   // [0] kind
	logic                            m_tvalid;
	logic                            m_tready;
	// [15:0] out_value, [20:16] out_row, [25:21] out_col, [31:26] zero
	logic [v2dc_pkg::OUT_DATA_W-1:0] m_tdata;
	logic                            m_tlast;

	int fails;
	int pending;
	int cycle_count = 0;
	int items_sent = 0;
	int samples_sent = 0;
	// percent chance per cycle that each side idles; set per phase by the sender
	int sender_idle = 0;
	int receiver_stall = 0;

	valid_2d_convolution uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

	valid_2d_convolution_checker watch (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.fails    (fails),
		.pending  (pending)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	always @(posedge clk) cycle_count <= cycle_count + 1;

	// Abort a hung run.
	initial begin
		wait (cycle_count >= CYCLE_LIMIT);
		$display("FAIL valid_2d_convolution");
		$finish;
	end

	// Mostly full-range values, with the two extremes mixed in often.
	function automatic logic [15:0] pick_value();
		case ($urandom_range(7))
			0: return 16'h8000;
			1: return 16'h7FFF;
			default: return 16'($urandom);
		endcase
	endfunction

	// Offer one item and hold it until the block takes it. The idling phase rotates every
	// 150 items: none, sender idle, receiver stalling, both lightly.
	task automatic offer(input logic kind, input logic [15:0] value);
		case ((items_sent / 150) % 4)
			0: begin
				sender_idle = 0;
				receiver_stall = 0;
			end
			1: begin
				sender_idle = 81;
				receiver_stall = 0;
			end
			2: begin
				sender_idle = 0;
				receiver_stall = 81;
			end
			default: begin
				sender_idle = 12;
				receiver_stall = 12;
			end
		endcase
		while ($urandom_range(99) < sender_idle) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= kind;
		s_tdata <= value;
		do @(posedge clk); while (!s_tready);
		items_sent++;
		if (kind == v2dc_pkg::KIND_IMAGE)
			samples_sent++;
	endtask

	// Result side: random back-pressure per phase, plus one long hold-off once a few hundred
	// results have gone by, so the pipeline fills and the block drops s_tready while the
	// sender keeps offering.
	initial begin : drain
		int taken;
		int hold_left;
		logic held;
		taken = 0;
		hold_left = 0;
		held = 1'b0;
		m_tready <= 1'b0;
		forever begin
			@(posedge clk);
			if (m_tvalid && m_tready)
				taken++;
			if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else if (!held && taken >= 300) begin
				held = 1'b1;
				hold_left = 400;
				m_tready <= 1'b0;
			end else begin
				m_tready <= ($urandom_range(99) >= receiver_stall);
			end
		end
	end

	initial begin : stimulus
		logic [15:0] corner_coefs[9];
		logic [15:0] corner_samples[16];
		int burst;
		corner_coefs = '{16'h7FFF, 16'h8000, 16'h0001, 16'hFFFF, 16'h0000,
			16'h5555, 16'hAAAA, 16'h0002, 16'h7FFF};
		corner_samples = '{16'h8000, 16'h7FFF, 16'h0000, 16'hFFFF, 16'h0001, 16'h5555,
			16'hAAAA, 16'h8000, 16'h8000, 16'h7FFF, 16'h7FFF, 16'h0000,
			16'hFFFF, 16'h8001, 16'h7FFE, 16'h0100};
		arst_n <= 1'b0;
		s_tvalid <= 1'b0;
		s_tdata <= '0;
		s_tuser <= v2dc_pkg::KIND_KERNEL;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: a full kernel of extreme coefficients (never leave a slot unwritten
		// before the first window), then the opening samples of the frame at extremes.
		foreach (corner_coefs[i])
			offer(v2dc_pkg::KIND_KERNEL, corner_coefs[i]);
		foreach (corner_samples[i])
			offer(v2dc_pkg::KIND_IMAGE, corner_samples[i]);

		// Random: mostly image samples, with occasional kernel reloads, full or partial,
		// landing anywhere in the frame. Run past the frame end so the last mark and the
		// wrap to row zero are both seen.
		while (items_sent < 1050 || samples_sent < 1040) begin
			if ($urandom_range(127) == 0) begin
				burst = ($urandom_range(3) == 0) ? 9 : $urandom_range(4, 1);
				repeat (burst) offer(v2dc_pkg::KIND_KERNEL, pick_value());
			end else begin
				offer(v2dc_pkg::KIND_IMAGE, pick_value());
			end
		end
		s_tvalid <= 1'b0;

		// Let the checker book the final item, drain what is still owed, then give stray
		// results a chance to show up.
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
		if (fails == 0 && pending == 0)
			$display("PASS valid_2d_convolution");
		else
			$display("FAIL valid_2d_convolution");
		$finish;
	end

endmodule
